### sv/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared constants, codes and types for the source text lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  // default widths
  localparam int POSITION_BITS_DEF = 16;
  localparam int LENGTH_BITS_DEF   = 8;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // lexer modes
  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_INT  = 3'd1;
  localparam logic [2:0] M_WORD = 3'd2;
  localparam logic [2:0] M_EQ   = 3'd3;
  localparam logic [2:0] M_BANG = 3'd4;
  localparam logic [2:0] M_GT   = 3'd5;
  localparam logic [2:0] M_LT   = 3'd6;

  // token kinds
  localparam logic [4:0] K_INT    = 5'd0;
  localparam logic [4:0] K_IDENT  = 5'd1;
  localparam logic [4:0] K_EXIT   = 5'd2;
  localparam logic [4:0] K_LET    = 5'd3;
  localparam logic [4:0] K_IF     = 5'd4;
  localparam logic [4:0] K_ELSE   = 5'd5;
  localparam logic [4:0] K_STAR   = 5'd6;
  localparam logic [4:0] K_SLASH  = 5'd7;
  localparam logic [4:0] K_PLUS   = 5'd8;
  localparam logic [4:0] K_MINUS  = 5'd9;
  localparam logic [4:0] K_SEMI   = 5'd10;
  localparam logic [4:0] K_LPAREN = 5'd11;
  localparam logic [4:0] K_RPAREN = 5'd12;
  localparam logic [4:0] K_ASSIGN = 5'd13;
  localparam logic [4:0] K_EQEQ   = 5'd14;
  localparam logic [4:0] K_NEQ    = 5'd15;
  localparam logic [4:0] K_GT     = 5'd16;
  localparam logic [4:0] K_GE     = 5'd17;
  localparam logic [4:0] K_LT     = 5'd18;
  localparam logic [4:0] K_LE     = 5'd19;
  localparam logic [4:0] K_LBRACE = 5'd20;
  localparam logic [4:0] K_RBRACE = 5'd21;
  localparam logic [4:0] K_EOF    = 5'd22;
  localparam logic [4:0] K_BAD    = 5'd23;
  localparam logic [4:0] K_BANG   = 5'd24;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5a;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7a;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  // keyword prefixes, first letter in the low byte
  localparam logic [31:0] KW_EXIT = 32'h7469_7865;
  localparam logic [31:0] KW_LET  = 32'h0074_656c;
  localparam logic [31:0] KW_IF   = 32'h0000_6669;
  localparam logic [31:0] KW_ELSE = 32'h6573_6c65;

  // decoded character class
  typedef struct packed {
    logic       is_space;
    logic       is_digit;
    logic       is_alpha;
    logic       is_hold;     // operator that may pair with a following '='
    logic [2:0] hold_mode;
    logic       is_single;   // gives a one-byte token at once
    logic [4:0] single_kind;
  } char_class_t;

endpackage

### sv/stl_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_class
// Character class decode for one source byte.
// ----------------------------------------------------------------------------
module stl_class
  import stl_pkg::*;
(
  input  logic [7:0]  char_code,
  output char_class_t cls
);

  always_comb begin
    cls             = '0;
    cls.hold_mode   = M_IDLE;
    cls.single_kind = K_BAD;
    cls.is_space    = (char_code == CH_SPACE) ||
                      (char_code >= CH_TAB && char_code <= CH_CR);
    cls.is_digit    = (char_code >= CH_0 && char_code <= CH_9);
    cls.is_alpha    = (char_code >= CH_UA && char_code <= CH_UZ) ||
                      (char_code >= CH_LA && char_code <= CH_LZ);
    // operators and brackets
    if (!cls.is_space && !cls.is_digit && !cls.is_alpha) begin
      unique case (char_code)
        CH_EQ:     begin cls.is_hold = 1'b1; cls.hold_mode = M_EQ;   end
        CH_BANG:   begin cls.is_hold = 1'b1; cls.hold_mode = M_BANG; end
        CH_GT:     begin cls.is_hold = 1'b1; cls.hold_mode = M_GT;   end
        CH_LT:     begin cls.is_hold = 1'b1; cls.hold_mode = M_LT;   end
        CH_STAR:   begin cls.is_single = 1'b1; cls.single_kind = K_STAR;   end
        CH_SLASH:  begin cls.is_single = 1'b1; cls.single_kind = K_SLASH;  end
        CH_PLUS:   begin cls.is_single = 1'b1; cls.single_kind = K_PLUS;   end
        CH_MINUS:  begin cls.is_single = 1'b1; cls.single_kind = K_MINUS;  end
        CH_SEMI:   begin cls.is_single = 1'b1; cls.single_kind = K_SEMI;   end
        CH_LPAREN: begin cls.is_single = 1'b1; cls.single_kind = K_LPAREN; end
        CH_RPAREN: begin cls.is_single = 1'b1; cls.single_kind = K_RPAREN; end
        CH_LBRACE: begin cls.is_single = 1'b1; cls.single_kind = K_LBRACE; end
        CH_RBRACE: begin cls.is_single = 1'b1; cls.single_kind = K_RBRACE; end
        default:   begin cls.is_single = 1'b1; cls.single_kind = K_BAD;    end
      endcase
    end
  end

endmodule

### sv/stl_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_step
// Lexer state registers and per-beat token logic; gives up to two results.
// ----------------------------------------------------------------------------
module stl_step
  import stl_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
  localparam int RES_W        = 5 + POSITION_BITS + LENGTH_BITS + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             in_end,
  input  logic [7:0]       char_code,
  input  char_class_t      cls,
  output logic [1:0]       res_cnt,
  output logic [RES_W-1:0] res0,     // last, length, start, kind
  output logic [RES_W-1:0] res1
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;

  logic [2:0]               mode, mode_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] pstart, pstart_next;
  logic [LENGTH_BITS-1:0]   plen, plen_next;
  logic [31:0]              prefix, prefix_next;

  logic                     flush_vld;
  logic [4:0]               flush_kind;
  logic [4:0]               word_kind;
  logic [4:0]               pair_kind;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [LENGTH_BITS-1:0]   plen_inc;
  logic [31:0]              prefix_add;

  logic                     a_vld, b_vld;
  logic [4:0]               a_kind, b_kind;
  logic [POSITION_BITS-1:0] a_start, b_start;
  logic [LENGTH_BITS-1:0]   a_len, b_len;

  // saturating counters
  assign pos_inc  = (pos == POS_MAX) ? pos : pos + 1'b1;
  assign plen_inc = (plen == LEN_MAX) ? plen : plen + 1'b1;

  // keyword match on kept prefix plus length
  always_comb begin
    priority if (plen == LENGTH_BITS'(4) && prefix == KW_EXIT) word_kind = K_EXIT;
    else if (plen == LENGTH_BITS'(3) && prefix == KW_LET)      word_kind = K_LET;
    else if (plen == LENGTH_BITS'(2) && prefix == KW_IF)       word_kind = K_IF;
    else if (plen == LENGTH_BITS'(4) && prefix == KW_ELSE)     word_kind = K_ELSE;
    else                                                       word_kind = K_IDENT;
  end

  // kind of the held token when it is flushed
  always_comb begin
    flush_vld  = 1'b1;
    flush_kind = K_INT;
    unique case (mode)
      M_INT:   flush_kind = K_INT;
      M_WORD:  flush_kind = word_kind;
      M_EQ:    flush_kind = K_ASSIGN;
      M_BANG:  flush_kind = K_BANG;
      M_GT:    flush_kind = K_GT;
      M_LT:    flush_kind = K_LT;
      default: flush_vld  = 1'b0;
    endcase
  end

  // two-byte operator kind
  always_comb begin
    unique case (mode)
      M_EQ:    pair_kind = K_EQEQ;
      M_BANG:  pair_kind = K_NEQ;
      M_GT:    pair_kind = K_GE;
      default: pair_kind = K_LE;
    endcase
  end

  // next letter into the word prefix
  always_comb begin
    prefix_add = '0;
    unique case (plen[1:0])
      2'd1:    prefix_add = {16'h0, char_code, 8'h0};
      2'd2:    prefix_add = {8'h0, char_code, 16'h0};
      2'd3:    prefix_add = {char_code, 24'h0};
      default: prefix_add = '0;
    endcase
  end

  // token step
  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    pstart_next = pstart;
    plen_next   = plen;
    prefix_next = prefix;
    a_vld       = 1'b0;
    a_kind      = flush_kind;
    a_start     = pstart;
    a_len       = plen;
    b_vld       = 1'b0;
    b_kind      = cls.single_kind;
    b_start     = pos;
    b_len       = LENGTH_BITS'(1);
    if (accept) begin
      priority if (in_end || char_code == CH_NUL) begin
        // flush, end of file, back to reset state
        a_vld       = flush_vld;
        b_vld       = 1'b1;
        b_kind      = K_EOF;
        b_len       = '0;
        mode_next   = M_IDLE;
        pos_next    = '0;
        pstart_next = '0;
        plen_next   = '0;
        prefix_next = '0;
      end else if ((mode == M_INT && cls.is_digit) ||
                   (mode == M_WORD && cls.is_alpha)) begin
        // token keeps growing
        if (mode == M_WORD && plen < LENGTH_BITS'(4)) begin
          prefix_next = prefix | prefix_add;
        end
        plen_next = plen_inc;
        pos_next  = pos_inc;
      end else if ((mode == M_EQ || mode == M_BANG || mode == M_GT || mode == M_LT) &&
                   char_code == CH_EQ) begin
        // two-byte operator
        a_vld     = 1'b1;
        a_kind    = pair_kind;
        a_len     = LENGTH_BITS'(2);
        mode_next = M_IDLE;
        pos_next  = pos_inc;
      end else begin
        // flush whatever is held, then start on this byte
        a_vld     = flush_vld;
        mode_next = M_IDLE;
        pos_next  = pos_inc;
        if (cls.is_digit) begin
          mode_next   = M_INT;
          pstart_next = pos;
          plen_next   = LENGTH_BITS'(1);
        end else if (cls.is_alpha) begin
          mode_next   = M_WORD;
          pstart_next = pos;
          plen_next   = LENGTH_BITS'(1);
          prefix_next = {24'h0, char_code};
        end else if (cls.is_hold) begin
          mode_next   = cls.hold_mode;
          pstart_next = pos;
          plen_next   = LENGTH_BITS'(1);
        end else if (cls.is_single) begin
          b_vld = 1'b1;
        end
      end
    end
  end

  // pack results in order, last on the final one
  always_comb begin
    res_cnt = {1'b0, a_vld} + {1'b0, b_vld};
    res0    = a_vld ? {~b_vld, a_len, a_start, a_kind} : {1'b1, b_len, b_start, b_kind};
    res1    = {1'b1, b_len, b_start, b_kind};
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      pstart <= '0;
      plen   <= '0;
      prefix <= '0;
    end else begin
      mode   <= mode_next;
      pos    <= pos_next;
      pstart <= pstart_next;
      plen   <= plen_next;
      prefix <= prefix_next;
    end
  end

endmodule

### sv/stl_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_res_fifo
// Small result queue: up to two results in a cycle, one out per ready cycle.
// ----------------------------------------------------------------------------
module stl_res_fifo
  import stl_pkg::*;
#(
  parameter int WIDTH = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_cnt,
  input  logic [WIDTH-1:0] din0,
  input  logic [WIDTH-1:0] din1,
  output logic             has_room,   // room for two more entries
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0]     mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count, count_next;
  logic                 pop;

  assign out_valid = (count != '0);
  assign has_room  = (count <= QCNT_BITS'(QUEUE_DEPTH - 2));
  assign pop       = out_valid && out_ready;
  assign dout      = mem[rd_ptr];

  assign count_next = count + QCNT_BITS'(push_cnt) - QCNT_BITS'(pop);

  // entry storage
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= din0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + 1'b1] <= din1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_BITS'(push_cnt);
      rd_ptr <= rd_ptr + QPTR_BITS'(pop);
      count  <= count_next;
    end
  end

endmodule

### sv/source_text_lexer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_lexer_core
// Byte-stream lexer: source bytes in, tokens (kind, start, length) out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one source byte per beat: s_tdata holds the byte,
//   s_tuser is 1 for an end-of-input beat (a zero byte acts the same).
//   Master side gives one token per beat; m_tlast marks the final token
//   caused by an input beat. An end beat flushes any held token, gives an
//   eof token (length 0) and returns the lexer to its reset state.
//   A token is formed combinationally from the beat that completes it and
//   written into the result queue. Input takes one byte per cycle while
//   each byte gives at most one token and m_tready stays high; a byte that
//   gives two tokens occupies the output for two beats. The byte decode and
//   the token step are combinational logic; results go into a four-entry
//   queue, and s_tready is high while that queue has room for two entries.
//   Reset (rst, synchronous) clears the lexer state and empties the queue.
//   When the receiver stalls, tokens wait in the queue and input keeps
//   flowing until the queue holds more than two entries.
// ----------------------------------------------------------------------------
module source_text_lexer_core
  import stl_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
  localparam int TOK_BITS     = 5 + POSITION_BITS + LENGTH_BITS,
  localparam int OUT_W        = ((TOK_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] char_code
  input  logic             s_tuser,   // [0] kind (end of input)
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // token_kind, token_start, token_length, zero fill
  output logic             m_tlast
);

  localparam int RES_W = TOK_BITS + 1;

  char_class_t      cls;
  logic             accept;
  logic [1:0]       res_cnt;
  logic [RES_W-1:0] res0, res1;
  logic             has_room;
  logic [RES_W-1:0] entry;

  assign s_tready = has_room;
  assign accept   = s_tvalid && s_tready;

  // byte decode
  stl_class u_class (
    .char_code (s_tdata),
    .cls       (cls)
  );

  // lexer state and token step
  stl_step #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_end    (s_tuser),
    .char_code (s_tdata),
    .cls       (cls),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  // result queue
  stl_res_fifo #(
    .WIDTH (RES_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (res_cnt),
    .din0      (res0),
    .din1      (res1),
    .has_room  (has_room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (entry)
  );

  // output beat
  assign m_tdata = OUT_W'(entry[TOK_BITS-1:0]);
  assign m_tlast = entry[RES_W-1];

endmodule

### sv/stl_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_chk
// Port-level checks for the source text lexer, bound to the top level.
// ----------------------------------------------------------------------------
module stl_chk
  import stl_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
  localparam int TOK_BITS     = 5 + POSITION_BITS + LENGTH_BITS,
  localparam int OUT_W        = ((TOK_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  logic [4:0]             tok_kind;
  logic [LENGTH_BITS-1:0] tok_len;

  assign tok_kind = m_tdata[4:0];
  assign tok_len  = m_tdata[TOK_BITS-1:5+POSITION_BITS];

  // a stalled beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat withdrawn while stalled");

  // a stalled beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // reset empties the queue and opens the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output not empty after reset");

  // eof always closes its input beat
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && tok_kind == K_EOF |-> m_tlast && tok_len == '0)
    else $error("eof token without tlast or with nonzero length");

  // every real token covers at least one byte
  a_tok_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && tok_kind != K_EOF |-> tok_len != '0)
    else $error("non-eof token with zero length");

endmodule

bind source_text_lexer_core stl_chk #(
  .POSITION_BITS (POSITION_BITS),
  .LENGTH_BITS   (LENGTH_BITS)
) u_stl_chk (.*);

### tb/source_text_lexer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_lexer_core_tb
// Self-checking bench for the byte-stream lexer. Source bytes go in on the
// slave side with random gaps. A token scoreboard keeps its own copy of the
// lexer state and predicts every token. Tokens leaving the master side under
// random backpressure are compared field by field in arrival order. Covered:
// keywords and near misses, all operators, paired '=' forms, lone bang, bad
// bytes, end beats, and saturation of the word length.
// ----------------------------------------------------------------------------
module source_text_lexer_core_tb;
  import stl_pkg::*;

  localparam int POS_W       = POSITION_BITS_DEF;
  localparam int LEN_W       = LENGTH_BITS_DEF;
  localparam int OUT_W       = ((5 + POS_W + LEN_W + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_BEATS = 220;

  typedef struct packed {
    logic [4:0]       kind;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             last;
  } token_t;

  // token scoreboard: lexer state copy plus queue of tokens still due
  class token_scoreboard;
    token_t           due[$];
    logic [2:0]       mode;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] held_start;
    logic [LEN_W-1:0] held_len;
    logic [31:0]      prefix;
    int               checked;
    int               errors;

    function new();
      clear_state();
      checked = 0;
      errors  = 0;
    endfunction

    function void clear_state();
      mode       = M_IDLE;
      pos        = '0;
      held_start = '0;
      held_len   = '0;
      prefix     = '0;
    endfunction

    function bit is_digit(logic [7:0] ch);
      return ch >= CH_0 && ch <= CH_9;
    endfunction

    function bit is_alpha(logic [7:0] ch);
      return (ch >= CH_UA && ch <= CH_UZ) || (ch >= CH_LA && ch <= CH_LZ);
    endfunction

    function void advance();
      if (pos != '1) pos++;
    endfunction

    function void grow();
      if (held_len != '1) held_len++;
    endfunction

    function void hold(logic [2:0] m);
      mode       = m;
      held_start = pos;
      held_len   = LEN_W'(1);
    endfunction

    function void emit(logic [4:0] kind, logic [POS_W-1:0] start, logic [LEN_W-1:0] len);
      token_t t;
      t.kind  = kind;
      t.start = start;
      t.len   = len;
      t.last  = 1'b0;
      due.insert(due.size(), t);
    endfunction

    // keywords are matched on kept prefix plus exact length
    function logic [4:0] word_kind();
      if (held_len == 4 && prefix == KW_EXIT) return K_EXIT;
      if (held_len == 3 && prefix == KW_LET) return K_LET;
      if (held_len == 2 && prefix == KW_IF) return K_IF;
      if (held_len == 4 && prefix == KW_ELSE) return K_ELSE;
      return K_IDENT;
    endfunction

    function void flush_held();
      logic [4:0] k;
      case (mode)
        M_INT:   k = K_INT;
        M_WORD:  k = word_kind();
        M_EQ:    k = K_ASSIGN;
        M_BANG:  k = K_BANG;
        M_GT:    k = K_GT;
        M_LT:    k = K_LT;
        default: begin
          mode = M_IDLE;
          return;
        end
      endcase
      emit(k, held_start, held_len);
      mode = M_IDLE;
    endfunction

    // byte seen with nothing held
    function void lex_fresh(logic [7:0] ch);
      if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
      end else if (is_digit(ch)) begin
        hold(M_INT);
      end else if (is_alpha(ch)) begin
        hold(M_WORD);
        prefix = {24'd0, ch};
      end else begin
        case (ch)
          CH_EQ:     hold(M_EQ);
          CH_BANG:   hold(M_BANG);
          CH_GT:     hold(M_GT);
          CH_LT:     hold(M_LT);
          CH_STAR:   emit(K_STAR, pos, LEN_W'(1));
          CH_SLASH:  emit(K_SLASH, pos, LEN_W'(1));
          CH_PLUS:   emit(K_PLUS, pos, LEN_W'(1));
          CH_MINUS:  emit(K_MINUS, pos, LEN_W'(1));
          CH_SEMI:   emit(K_SEMI, pos, LEN_W'(1));
          CH_LPAREN: emit(K_LPAREN, pos, LEN_W'(1));
          CH_RPAREN: emit(K_RPAREN, pos, LEN_W'(1));
          CH_LBRACE: emit(K_LBRACE, pos, LEN_W'(1));
          CH_RBRACE: emit(K_RBRACE, pos, LEN_W'(1));
          default:   emit(K_BAD, pos, LEN_W'(1));
        endcase
      end
    endfunction

    // note one accepted input beat and queue the tokens it causes
    function void note_byte(bit eoi, logic [7:0] ch);
      int         n_due;
      bit         done;
      logic [4:0] k;
      n_due = due.size();
      done  = 1'b0;
      if (eoi || ch == CH_NUL) begin
        flush_held();
        emit(K_EOF, pos, '0);
        clear_state();
      end else begin
        case (mode)
          M_INT: if (is_digit(ch)) begin
            grow();
            advance();
            done = 1'b1;
          end
          M_WORD: if (is_alpha(ch)) begin
            if (held_len < 4) prefix = prefix | ({24'd0, ch} << (8 * held_len));
            grow();
            advance();
            done = 1'b1;
          end
          M_EQ, M_BANG, M_GT, M_LT: if (ch == CH_EQ) begin
            k = (mode == M_EQ) ? K_EQEQ : (mode == M_BANG) ? K_NEQ :
                (mode == M_GT) ? K_GE : K_LE;
            emit(k, held_start, LEN_W'(2));
            mode = M_IDLE;
            advance();
            done = 1'b1;
          end
          default: ;
        endcase
        if (!done) begin
          flush_held();
          lex_fresh(ch);
          advance();
        end
      end
      if (due.size() > n_due) due[$].last = 1'b1;
    endfunction

    // compare one token from the master side with the oldest due token
    function void check_token(logic [4:0] kind, logic [POS_W-1:0] start,
                              logic [LEN_W-1:0] len, logic last);
      token_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: token with none due: kind %0d start %0d length %0d last %0b",
                 $time, kind, start, len, last);
        return;
      end
      want = due.pop_front();
      checked++;
      if (kind !== want.kind) begin
        errors++;
        $display("%0t: token_kind expected %0d actual %0d", $time, want.kind, kind);
      end
      if (start !== want.start) begin
        errors++;
        $display("%0t: token_start expected %0d actual %0d", $time, want.start, start);
      end
      if (len !== want.len) begin
        errors++;
        $display("%0t: token_length expected %0d actual %0d", $time, want.len, len);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  token_scoreboard sb = new();
  bit quiet;       // no random gaps on either side while set
  bit hold_req;
  bit holding;
  int beats_sent;
  int ends_sent;

  always #5 clk = ~clk;

  source_text_lexer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic idle_input(input int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 1'($urandom);
    end
  endtask

  task automatic send_beat(input bit eoi, input logic [7:0] ch);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= eoi;
    s_tdata  <= ch;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.note_byte(eoi, ch);
    beats_sent++;
    if (eoi || ch == CH_NUL) ends_sent++;
    idle_input(pick_gap());
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
  endtask

  // n random bytes drawn from lo..hi
  task automatic send_run(input logic [7:0] lo, input logic [7:0] hi, input int n);
    for (int i = 0; i < n; i++) send_beat(1'b0, 8'($urandom_range(lo, hi)));
  endtask

  task automatic send_letters(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) send_beat(1'b0, 8'($urandom_range(CH_UA, CH_UZ)));
      else send_beat(1'b0, 8'($urandom_range(CH_LA, CH_LZ)));
    end
  endtask

  // stop offering, then wait for every due token
  task automatic drain();
    idle_input(1);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // one random piece of source text, mostly well formed
  task automatic random_fragment();
    string kws[4];
    string s;
    int    r;
    int    i;
    kws[0] = "exit";
    kws[1] = "let";
    kws[2] = "if";
    kws[3] = "else";
    r = $urandom_range(0, 99);
    if (r < 12) begin
      send_text(kws[$urandom_range(0, 3)]);
    end else if (r < 20) begin
      // near misses of keywords
      s = kws[$urandom_range(0, 3)];
      case ($urandom_range(0, 3))
        0: s = s.substr(0, s.len() - 2);
        1: s = {s, "s"};
        2: s[0] = s[0] - 8'd32;
        default: begin
          i = $urandom_range(0, s.len() - 1);
          s[i] = 8'($urandom_range(CH_LA, CH_LZ));
        end
      endcase
      send_text(s);
    end else if (r < 32) begin
      send_letters($urandom_range(0, 3) == 0 ? $urandom_range(5, 12) : $urandom_range(1, 4));
    end else if (r < 42) begin
      send_run(CH_0, CH_9, $urandom_range(1, 6));
    end else if (r < 57) begin
      s = "*/+-;(){}";
      send_beat(1'b0, s[$urandom_range(0, s.len() - 1)]);
    end else if (r < 72) begin
      s = "=!<>";
      send_beat(1'b0, s[$urandom_range(0, 3)]);
      if ($urandom_range(0, 1)) send_beat(1'b0, CH_EQ);
    end else if (r < 84) begin
      send_run(CH_TAB, CH_CR, $urandom_range(0, 1));
      send_beat(1'b0, CH_SPACE);
    end else if (r < 92) begin
      if ($urandom_range(0, 1)) send_run(8'h80, 8'hff, 1);
      else send_run(8'h01, 8'h7f, 1);
    end else if (r < 96) begin
      send_beat(1'b0, CH_NUL);
    end else begin
      send_beat(1'b1, 8'($urandom));
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin : sink
    int n;
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
        holding = 1'b0;
      end
      n = pick_gap();
      repeat (n) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      n = $urandom_range(1, 8);
      repeat (n) begin
        @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // token checks at the rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready)
      sb.check_token(m_tdata[4:0], m_tdata[5 +: POS_W], m_tdata[5 + POS_W +: LEN_W], m_tlast);
  end

  // stimulus
  initial begin : stimulus
    int stop_at;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: flush plus token, lone bang, end beats, extreme bytes
    send_text("if x1>=9!<a+");
    send_beat(1'b1, 8'hA5);
    send_text("exit{}");
    send_beat(1'b0, 8'hff);
    send_beat(1'b0, 8'h01);
    send_beat(1'b0, CH_NUL);
    send_text("!");
    send_beat(1'b1, 8'h00);
    drain();

    // fill the block while the receiver holds off
    quiet    = 1'b1;
    hold_req = 1'b1;
    while (!holding) @(posedge clk);
    for (int i = 0; i < 5; i++) send_text(";+-*/(){}");
    send_beat(1'b1, 8'h5a);
    quiet = 1'b0;
    drain();

    // random text
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 99) < 4) quiet = ~quiet;
      random_fragment();
    end
    quiet = 1'b0;
    send_beat(1'b1, 8'($urandom));

    // a word past the length limit
    send_text("else");
    send_letters(252);
    send_beat(1'b0, CH_SPACE);
    send_beat(1'b1, 8'($urandom));

    drain();
    repeat (20) @(posedge clk);
    $display("run covered %0d input beats, %0d of them end of input, and %0d tokens",
             beats_sent, ends_sent, sb.checked);
    $display("including keyword near misses, a 255-byte saturated word and a long stall");
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("** source_text_lexer_core: PASSED **");
    end else begin
      $display("** source_text_lexer_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d tokens still due", sb.due.size());
    $display("** source_text_lexer_core: FAILED **");
    $finish;
  end

endmodule
